// File: rtl/core/cdsq_pkg.sv
// ----------------------------------------------------------------------------
// cdsq_pkg
// Types and constants shared by the subchannel Q frame generator.
// ----------------------------------------------------------------------------
package cdsq_pkg;

  localparam int MaxTracksDefault = 99;
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam logic [6:0] RegFirstTrack = 7'd0;
  localparam logic [6:0] RegTrackCount = 7'd1;
  localparam logic [23:0] MsfLimit = 24'd450000;

  typedef struct packed {
    logic        command;
    logic [6:0]  track_slot;
    logic [18:0] start_sector;
    logic [12:0] pregap_len;
    logic [12:0] data_pregap_len;
    logic [18:0] body_len;
    logic [12:0] postgap_len;
    logic        is_data;
    logic signed [19:0] sector_addr;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  q_control_adr;
    logic [7:0]  q_track_bcd;
    logic        q_index_bcd;
    logic [7:0]  rel_minute;
    logic [6:0]  rel_second;
    logic [6:0]  rel_frame;
    logic [7:0]  abs_minute;
    logic [6:0]  abs_second;
    logic [6:0]  abs_frame;
    logic [15:0] q_crc;
    logic        pause_flag;
    logic        track_found;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // write table entry from the input word
    logic capture;   // latch the query word
    logic rd;        // issue table read for the current walk slot
    logic check;     // compare registered read data against the address
    logic adv;       // step the walk counter
    logic prev_rd;   // read the preceding track's data flag
    logic form;      // compute times from the matched entry
    logic msf;       // one step of the sector to MSF split
    logic crc;       // one byte of the CRC
    logic emit;      // drive the result strobe
  } ctl_t;

  typedef struct packed {
    logic walk_done;
    logic hit;
    logic msf_done;
    logic crc_done;
  } sts_t;

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  r;
    // Multiplying by 205/2048 gives the tens digit for every value up to 99.
    p = 15'(v) * 15'd205;
    t = p[14:11];
    r = v - 7'(t) * 7'd10;
    return {t, r[3:0]};
  endfunction

endpackage

// File: rtl/core/cdsq_datapath.sv
// ----------------------------------------------------------------------------
// cdsq_datapath
// Track table memory, walk compare, MSF split and CRC over the Q bytes.
// ----------------------------------------------------------------------------
module cdsq_datapath #(
  parameter int MaxTracks = cdsq_pkg::MaxTracksDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  cdsq_pkg::in_word_t  in_word,
  input  logic [6:0]          base_track,
  input  logic [6:0]          track_count,
  input  cdsq_pkg::ctl_t      ctl,
  output cdsq_pkg::sts_t      sts,
  output logic                result,
  output cdsq_pkg::out_word_t result_word
);

  localparam int AW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;

  // Table entry: begin, gap before, data gap, length, gap after, data flag.
  typedef struct packed {
    logic [18:0] beg;
    logic [12:0] gb;
    logic [12:0] dg;
    logic [18:0] len;
    logic [12:0] ga;
    logic        dat;
  } entry_t;

  entry_t mem [MaxTracks];
  entry_t rd_q;
  logic   flag_mem [MaxTracks];
  logic   prev_flag;

  logic signed [19:0] lba;
  logic [6:0]  k;
  logic [7:0]  t;          // track number of the matched entry
  logic [7:0]  t_rd;       // track number of the entry in rd_q
  logic        rd_ok;
  logic        hit;
  logic        walk_done;

  // Load writes.
  logic ld_ok;
  assign ld_ok = (in_word.track_slot != 7'd0) &&
                 ({1'b0, in_word.track_slot} <= 8'(MaxTracks));

  logic [7:0] t_cur;
  assign t_cur = 8'(base_track) + 8'(k);
  logic t_valid;
  assign t_valid = (t_cur != 8'd0) && (t_cur <= 8'(MaxTracks));

  always_ff @(posedge clk) begin
    if (ctl.load && ld_ok) begin
      mem[AW'(in_word.track_slot - 7'd1)] <= '{in_word.start_sector, in_word.pregap_len,
        in_word.data_pregap_len, in_word.body_len, in_word.postgap_len, in_word.is_data};
      flag_mem[AW'(in_word.track_slot - 7'd1)] <= in_word.is_data;
    end
    if (ctl.rd) begin
      rd_q <= mem[AW'(t_cur - 8'd1)];
    end
    if (ctl.prev_rd) begin
      prev_flag <= flag_mem[AW'(t - 8'd2)];
    end
  end

  // Span compare, 22-bit signed.
  logic signed [21:0] lo, hi, a22;
  assign a22 = 22'(lba);
  assign lo = $signed({3'b0, rd_q.beg}) - $signed({9'b0, rd_q.dg}) - $signed({9'b0, rd_q.gb});
  assign hi = $signed({3'b0, rd_q.beg}) + $signed({3'b0, rd_q.len}) + $signed({9'b0, rd_q.ga});

  logic match;
  assign match = ctl.check && rd_ok && (a22 >= lo) && (a22 < hi);

  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      hit <= 1'b0;
      walk_done <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (ctl.capture) begin
        lba <= in_word.sector_addr;
        k <= '0;
        hit <= 1'b0;
        walk_done <= (track_count == 7'd0);
        rd_ok <= 1'b0;
      end
      if (ctl.rd) begin
        rd_ok <= t_valid;
        t_rd <= t_cur;
      end
      if (ctl.adv) begin
        k <= k + 7'd1;
        if ((k + 7'd1 >= track_count) || match) walk_done <= 1'b1;
      end
      if (match) begin
        hit <= 1'b1;
        ent <= rd_q;
        t <= t_rd;
      end
    end
  end

  assign sts.walk_done = walk_done;
  assign sts.hit = hit;

  // Form stage: relative and absolute counts, then split both by repeated
  // subtraction of one minute, then of one second.
  logic signed [21:0] rel_s, abs_s, d;
  logic [23:0] rc, ac;
  logic [6:0]  rmin, amin, rsec, asec;
  logic [1:0]  ph;    // 0 minutes, 1 seconds, 2 done
  logic        in_pregap;
  logic        pause;
  logic [3:0]  ctrl;

  assign d = a22 - $signed({3'b0, ent.beg});
  assign rel_s = in_pregap ? (-d - 22'sd1) : d;
  assign abs_s = a22 + 22'sd150;

  always_ff @(posedge clk) begin
    if (ctl.form) begin
      in_pregap <= d < 0;
      pause <= (d < 0) || (d >= $signed({3'b0, ent.len}));
      ctrl <= (ent.dat && !(d < -22'sd150 && base_track < t[6:0] && t >= 8'd2 && !prev_flag))
              ? 4'd4 : 4'd0;
    end
  end

  // The first MSF cycle loads the counts; a separate flag tracks that.
  logic loaded;
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (ctl.form) begin
      loaded <= 1'b0;
      rmin <= '0; amin <= '0; rsec <= '0; asec <= '0; ph <= 2'd0;
    end else if (ctl.msf) begin
      if (!loaded) begin
        loaded <= 1'b1;
        rc <= (rel_s < 0) ? 24'd0 : 24'(rel_s);
        ac <= (abs_s < 0) ? 24'd0 : 24'(abs_s);
      end else if (ph == 2'd0) begin
        if (rc >= 24'd4500 && rmin != 7'd100) begin
          rc <= rc - 24'd4500; rmin <= rmin + 7'd1;
        end
        if (ac >= 24'd4500 && amin != 7'd100) begin
          ac <= ac - 24'd4500; amin <= amin + 7'd1;
        end
        if (!(rc >= 24'd4500 && rmin != 7'd100) && !(ac >= 24'd4500 && amin != 7'd100))
          ph <= 2'd1;
      end else if (ph == 2'd1) begin
        // A saturated count needs no seconds.
        if (rc >= 24'd75 && rmin != 7'd100) begin
          rc <= rc - 24'd75; rsec <= rsec + 7'd1;
        end
        if (ac >= 24'd75 && amin != 7'd100) begin
          ac <= ac - 24'd75; asec <= asec + 7'd1;
        end
        if (!(rc >= 24'd75 && rmin != 7'd100) && !(ac >= 24'd75 && amin != 7'd100))
          ph <= 2'd2;
      end
    end
  end
  assign sts.msf_done = loaded && (ph == 2'd2);

  // Saturated BCD values; minute 100 means the count reached 100 minutes.
  logic [7:0] rm_b, rs_b, rf_b, am_b, as_b, af_b;
  always_comb begin
    if (rmin == 7'd100) begin
      rm_b = 8'h99; rs_b = 8'h59; rf_b = 8'h74;
    end else begin
      rm_b = cdsq_pkg::to_bcd(rmin); rs_b = cdsq_pkg::to_bcd(rsec);
      rf_b = cdsq_pkg::to_bcd(rc[6:0]);
    end
    if (amin == 7'd100) begin
      am_b = 8'h99; as_b = 8'h59; af_b = 8'h74;
    end else begin
      am_b = cdsq_pkg::to_bcd(amin); as_b = cdsq_pkg::to_bcd(asec);
      af_b = cdsq_pkg::to_bcd(ac[6:0]);
    end
  end

  logic [7:0] qb [10];
  assign qb[0] = {ctrl, 4'h1};
  assign qb[1] = cdsq_pkg::to_bcd(t[6:0]);
  assign qb[2] = {7'd0, !in_pregap};
  assign qb[3] = rm_b;
  assign qb[4] = rs_b;
  assign qb[5] = rf_b;
  assign qb[6] = 8'd0;
  assign qb[7] = am_b;
  assign qb[8] = as_b;
  assign qb[9] = af_b;

  // CRC, one byte per cycle.
  logic [15:0] crc;
  logic [3:0]  bi;
  logic [15:0] crc_n;
  always_comb begin
    crc_n = crc ^ {qb[bi], 8'd0};
    for (int i = 0; i < 8; i++) begin
      crc_n = crc_n[15] ? ((crc_n << 1) ^ 16'h1021) : (crc_n << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bi <= '0;
    end else if (ctl.form) begin
      bi <= '0;
      crc <= '0;
    end else if (ctl.crc && bi != 4'd10) begin
      crc <= crc_n;
      bi <= bi + 4'd1;
    end
  end
  assign sts.crc_done = (bi == 4'd10);

  always_ff @(posedge clk) begin
    if (rst) begin
      result <= 1'b0;
    end else begin
      result <= ctl.emit;
      if (ctl.emit) begin
        if (hit) begin
          result_word <= '{qb[0], qb[1], !in_pregap, rm_b, rs_b[6:0], rf_b[6:0], am_b,
                           as_b[6:0], af_b[6:0], ~crc, pause, 1'b1};
        end else begin
          result_word <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/core/cdsq_ctrl.sv
// ----------------------------------------------------------------------------
// cdsq_ctrl
// Sequencer for load, track walk, MSF split, CRC and result.
// ----------------------------------------------------------------------------
module cdsq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  cdsq_pkg::sts_t     sts,
  output logic               busy,
  output cdsq_pkg::ctl_t     ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_PREV, S_FORM, S_MSF, S_CRC, S_EMIT
  } state_t;

  state_t state;

  always_comb begin
    ctl = '0;
    ctl.load    = (state == S_IDLE) && start && command == cdsq_pkg::CmdLoad;
    ctl.capture = (state == S_IDLE) && start && command == cdsq_pkg::CmdQuery;
    ctl.rd      = (state == S_RD);
    ctl.check   = (state == S_CHK);
    ctl.adv     = (state == S_CHK);
    ctl.prev_rd = (state == S_PREV);
    ctl.form    = (state == S_FORM);
    ctl.msf     = (state == S_MSF);
    ctl.crc     = (state == S_CRC);
    ctl.emit    = (state == S_EMIT);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (ctl.capture) state <= S_RD;
        S_RD: begin
          // A capture with an empty table lands here with the walk finished.
          if (sts.walk_done) begin
            if (sts.hit) state <= S_PREV;
            else state <= S_EMIT;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK:  state <= S_RD;
        S_PREV: state <= S_FORM;
        S_FORM: state <= S_MSF;
        S_MSF:  if (sts.msf_done) state <= S_CRC;
        S_CRC:  if (sts.crc_done) state <= S_EMIT;
        S_EMIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/cd_subq_frame_generator.sv
// ----------------------------------------------------------------------------
// cd_subq_frame_generator
// Q subchannel position frame generator over a loaded track table.
// ----------------------------------------------------------------------------
// A load word is taken in the cycle it is offered and busy does not rise. A
// query walks the table, reading each track entry and then comparing it. With
// no match, or with an empty table, it then goes straight to the result. On a
// match, the walk is followed by one read of the preceding track's flag, a
// forming step, the split of both sector counts into minutes and seconds by
// repeated subtraction and the CRC at one byte per cycle. busy falls in the
// cycle in which the result strobe is high, so the next word can be taken at
// the edge that ends it. The strobe is given once for every query, for one
// cycle, and cannot be held off by the receiver.
module cd_subq_frame_generator #(
  parameter int MaxTracks = cdsq_pkg::MaxTracksDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  cdsq_pkg::in_word_t  in_word,
  output logic                result,
  output cdsq_pkg::out_word_t result_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_index,
  input  logic [6:0]          cfg_data
);

  logic [6:0] base_track, track_count;
  cdsq_pkg::ctl_t ctl;
  cdsq_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_track <= 7'd1;
      track_count <= 7'd0;
    end else if (cfg_valid) begin
      if (cfg_index == cdsq_pkg::RegFirstTrack) base_track <= cfg_data;
      else if (cfg_index == cdsq_pkg::RegTrackCount) track_count <= cfg_data;
    end
  end

  cdsq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(in_word.command),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  cdsq_datapath #(.MaxTracks(MaxTracks)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .base_track(base_track),
    .track_count(track_count), .ctl(ctl), .sts(sts), .result(result),
    .result_word(result_word)
  );

endmodule

// File: tb/sv/cd_subq_frame_generator_test.sv
// ----------------------------------------------------------------------------
// cd_subq_frame_generator_test
// Checks Q position frames for table loads and sector queries, with register
// settings, random gaps and a per-word comparison against a local predictor.
// ----------------------------------------------------------------------------
module cd_subq_frame_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected frames for accepted queries, oldest first.
  class frame_scoreboard;
    cdsq_pkg::out_word_t pending[$];
    int        fails;
    int        frames_seen;
    int        hits_seen;

    function void note_query(cdsq_pkg::out_word_t w);
      pending.push_back(w);
    endfunction

    function void check_frame(cdsq_pkg::out_word_t got);
      cdsq_pkg::out_word_t exp;
      frames_seen++;
      if (pending.size() == 0) begin
        $error("result with no expected frame waiting");
        fails++;
        return;
      end
      exp = pending.pop_front();
      if (got.track_found) hits_seen++;
      if (got !== exp) begin
        fails++;
        if (got.q_control_adr !== exp.q_control_adr)
          $error("q_control_adr exp %h got %h", exp.q_control_adr, got.q_control_adr);
        if (got.q_track_bcd !== exp.q_track_bcd)
          $error("q_track_bcd exp %h got %h", exp.q_track_bcd, got.q_track_bcd);
        if (got.q_index_bcd !== exp.q_index_bcd)
          $error("q_index_bcd exp %h got %h", exp.q_index_bcd, got.q_index_bcd);
        if (got.rel_minute !== exp.rel_minute)
          $error("rel_minute exp %h got %h", exp.rel_minute, got.rel_minute);
        if (got.rel_second !== exp.rel_second)
          $error("rel_second exp %h got %h", exp.rel_second, got.rel_second);
        if (got.rel_frame !== exp.rel_frame)
          $error("rel_frame exp %h got %h", exp.rel_frame, got.rel_frame);
        if (got.abs_minute !== exp.abs_minute)
          $error("abs_minute exp %h got %h", exp.abs_minute, got.abs_minute);
        if (got.abs_second !== exp.abs_second)
          $error("abs_second exp %h got %h", exp.abs_second, got.abs_second);
        if (got.abs_frame !== exp.abs_frame)
          $error("abs_frame exp %h got %h", exp.abs_frame, got.abs_frame);
        if (got.q_crc !== exp.q_crc)
          $error("q_crc exp %h got %h", exp.q_crc, got.q_crc);
        if (got.pause_flag !== exp.pause_flag)
          $error("pause_flag exp %b got %b", exp.pause_flag, got.pause_flag);
        if (got.track_found !== exp.track_found)
          $error("track_found exp %b got %b", exp.track_found, got.track_found);
      end
    endfunction
  endclass

  localparam int InWordBits = $bits(cdsq_pkg::in_word_t);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  cdsq_pkg::in_word_t  in_word = '0;
  logic      result;
  cdsq_pkg::out_word_t result_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [6:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  cd_subq_frame_generator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_scoreboard sb = new();

  // Local copy of the table and registers.
  logic [18:0] tbl_begin[1:99];
  logic [12:0] tbl_gap_before[1:99];
  logic [12:0] tbl_data_gap[1:99];
  logic [18:0] tbl_length[1:99];
  logic [12:0] tbl_gap_after[1:99];
  logic        tbl_data[1:99];
  bit          tbl_written[1:99];
  int          reg_first;
  int          reg_count;
  int          queries_sent;
  int          loads_sent;

  function automatic cdsq_pkg::in_word_t rand_word();
    return cdsq_pkg::in_word_t'(InWordBits'({$urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic logic [7:0] bcd_of(int v);
    return 8'((v / 10) * 16 + v % 10);
  endfunction

  function automatic void split_msf(longint n, output logic [7:0] mm, output logic [7:0] ss,
                                    output logic [7:0] ff);
    if (n < 0) n = 0;
    if (n >= 450000) begin
      mm = bcd_of(99); ss = bcd_of(59); ff = bcd_of(74);
    end else begin
      ff = bcd_of(int'(n % 75));
      ss = bcd_of(int'((n / 75) % 60));
      mm = bcd_of(int'(n / 4500));
    end
  endfunction

  function automatic logic [15:0] q_crc_of(logic [7:0] q[10]);
    logic [15:0] crc;
    crc = 16'h0;
    for (int i = 0; i < 10; i++) begin
      crc ^= {q[i], 8'h00};
      for (int b = 0; b < 8; b++)
        crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
    end
    return ~crc;
  endfunction

  function automatic cdsq_pkg::out_word_t predict_frame(logic signed [19:0] addr);
    cdsq_pkg::out_word_t o;
    longint      lba, lo, hi, beg;
    int          t;
    bit          hit;
    logic [3:0]  control;
    logic [7:0]  rm, rs, rf, am, as_, af;
    logic [7:0]  q[10];
    o = '0;
    hit = 0;
    lba = addr;
    for (int k = 0; k < reg_count; k++) begin
      t = reg_first + k;
      if (t < 1 || t > 99) continue;
      lo = longint'(tbl_begin[t]) - tbl_data_gap[t] - tbl_gap_before[t];
      hi = longint'(tbl_begin[t]) + tbl_length[t] + tbl_gap_after[t];
      if (lba >= lo && lba < hi) begin
        hit = 1;
        break;
      end
    end
    if (!hit) return o;
    beg = tbl_begin[t];
    if (lba < beg) split_msf(beg - 1 - lba, rm, rs, rf);
    else split_msf(lba - beg, rm, rs, rf);
    split_msf(lba + 150, am, as_, af);
    control = tbl_data[t] ? 4'd4 : 4'd0;
    // An audio track ahead of a data track lends its control deep in the pregap.
    if (lba - beg < -150 && tbl_data[t] && reg_first < t && t >= 2 && !tbl_data[t-1])
      control = 4'd0;
    q[0] = {control, 4'h1};
    q[1] = bcd_of(t);
    q[2] = {7'd0, lba >= beg};
    q[3] = rm; q[4] = rs; q[5] = rf; q[6] = 8'h00;
    q[7] = am; q[8] = as_; q[9] = af;
    o.q_control_adr = q[0];
    o.q_track_bcd = q[1];
    o.q_index_bcd = lba >= beg;
    o.rel_minute = rm; o.rel_second = rs[6:0]; o.rel_frame = rf[6:0];
    o.abs_minute = am; o.abs_second = as_[6:0]; o.abs_frame = af[6:0];
    o.q_crc = q_crc_of(q);
    o.pause_flag = (lba < beg || lba >= beg + tbl_length[t]);
    o.track_found = 1'b1;
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && result) sb.check_frame(result_word);
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    repeat (n) @(posedge clk);
  endtask

  // Hands one word to the block and updates the predictor on acceptance.
  task automatic send_word(cdsq_pkg::in_word_t w);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    in_word <= rand_word();
    if (w.command == cdsq_pkg::CmdLoad) begin
      loads_sent++;
      if (w.track_slot >= 1 && w.track_slot <= 99) begin
        tbl_begin[w.track_slot] = w.start_sector;
        tbl_gap_before[w.track_slot] = w.pregap_len;
        tbl_data_gap[w.track_slot] = w.data_pregap_len;
        tbl_length[w.track_slot] = w.body_len;
        tbl_gap_after[w.track_slot] = w.postgap_len;
        tbl_data[w.track_slot] = w.is_data;
        tbl_written[w.track_slot] = 1;
      end
    end else begin
      queries_sent++;
      sb.note_query(predict_frame(w.sector_addr));
    end
    idle_gap();
  endtask

  task automatic load_track(int slot, int sb_, int pg, int dpg, int bl, int po, bit dat);
    cdsq_pkg::in_word_t w;
    w = rand_word();
    w.command = cdsq_pkg::CmdLoad;
    w.track_slot = 7'(slot);
    w.start_sector = 19'(sb_);
    w.pregap_len = 13'(pg);
    w.data_pregap_len = 13'(dpg);
    w.body_len = 19'(bl);
    w.postgap_len = 13'(po);
    w.is_data = dat;
    send_word(w);
  endtask

  // Queries only walk slots that are loaded, so unwritten entries are never read.
  function automatic bit walk_is_safe();
    for (int k = 0; k < reg_count; k++)
      if (reg_first + k <= 99 && !tbl_written[reg_first + k]) return 0;
    return 1;
  endfunction

  task automatic query(int addr);
    cdsq_pkg::in_word_t w;
    w = rand_word();
    w.command = cdsq_pkg::CmdQuery;
    w.sector_addr = 20'(addr);
    if (walk_is_safe()) send_word(w);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic write_reg(logic [6:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 7'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == cdsq_pkg::RegFirstTrack) reg_first = val;
    else reg_count = val;
    @(posedge clk);
  endtask

  // Lays out a random disc over slots lo..hi, contiguous until the position wraps.
  task automatic build_disc(int lo, int hi, bit huge);
    int pos, bl, pg, dpg, po;
    pos = $urandom_range(0, 300);
    for (int s = lo; s <= hi; s++) begin
      pg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4499) : $urandom_range(0, 300);
      dpg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4499) : $urandom_range(0, 300);
      po = $urandom_range(0, 2) == 0 ? $urandom_range(0, 4499) : 0;
      bl = huge ? $urandom_range(1000, 60000) : $urandom_range(0, 3000);
      pos += pg + dpg;
      if (pos > 449849) pos = $urandom_range(0, 449849);
      load_track(s, pos, pg, dpg, bl, po, $urandom_range(0, 1));
      pos += bl + po;
    end
  endtask

  task automatic random_queries(int n, int lo, int hi);
    int t, a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        t = $urandom_range(lo, hi);
        a = int'(tbl_begin[t]) + $urandom_range(0, 1) * int'(tbl_length[t])
            - $urandom_range(0, int'(tbl_gap_before[t]) + int'(tbl_data_gap[t]) + 2)
            + $urandom_range(0, int'(tbl_gap_after[t]) + 2);
        if (a < -150) a = -150;
        if (a > 449849) a = 449849;
      end else begin
        a = $urandom_range(0, 450000) - 150;
      end
      query(a);
      // Occasional stray loads, all to ignored slots.
      if ($urandom_range(0, 15) == 0)
        load_track($urandom_range(0, 1) ? 0 : $urandom_range(100, 127), $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end
  endtask

  initial begin
    #20ms;
    $display("cd_subq_frame_generator regression: fail");
    $finish;
  end

  initial begin
    reg_first = 1;
    reg_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, then a small disc with extremes.
    query(-150);
    query(449849);
    query(-524288);
    query(524287);
    load_track(1, 0, 0, 0, 0, 0, 1'b0);
    load_track(2, 300, 100, 100, 449999, 4499, 1'b1);
    load_track(99, 449849, 4499, 4499, 449999, 4499, 1'b1);
    load_track(98, 449849 - 9000, 0, 0, 0, 0, 1'b0);
    load_track(0, 0, 8191, 8191, 524287, 8191, 1'b1);
    load_track(127, 524287, 0, 0, 0, 0, 1'b0);
    drain();
    write_reg(cdsq_pkg::RegFirstTrack, 1);
    write_reg(cdsq_pkg::RegTrackCount, 2);
    query(0);
    query(-1);
    query(99);
    query(299);
    query(300);
    query(449849);
    query(-150);
    drain();
    write_reg(cdsq_pkg::RegTrackCount, 3);
    drain();
    write_reg(cdsq_pkg::RegFirstTrack, 98);
    write_reg(cdsq_pkg::RegTrackCount, 99);
    query(449849);
    query(449849 - 300);
    query(449849 - 9001);
    query(449849 - 9000);
    query(-150);
    query(449849 - 4000);
    drain();
    write_reg(cdsq_pkg::RegFirstTrack, 99);
    write_reg(cdsq_pkg::RegTrackCount, 0);
    query(449849);
    drain();

    // Random discs of varied shapes.
    for (int ph = 0; ph < 8; ph++) begin
      int lo, hi;
      lo = (ph == 0) ? 1 : (ph == 1) ? 95 : $urandom_range(1, 90);
      hi = (ph == 1) ? 99 : lo + $urandom_range(0, (ph % 3 == 0) ? 8 : 3);
      if (ph == 2) hi = lo;
      build_disc(lo, hi, ph == 3);
      drain();
      write_reg(cdsq_pkg::RegFirstTrack, lo);
      write_reg(cdsq_pkg::RegTrackCount, (ph == 1) ? 99 : hi - lo + 1);
      random_queries(60, lo, hi);
      drain();
      if (lo > 1) begin
        write_reg(cdsq_pkg::RegFirstTrack, lo + 1);
        write_reg(cdsq_pkg::RegTrackCount, hi - lo);
        random_queries(10, lo, hi);
        drain();
      end
    end

    drain();
    $display("covered %0d loads and %0d queries, %0d frames checked, %0d hit a track",
             loads_sent, queries_sent, sb.frames_seen, sb.hits_seen);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("cd_subq_frame_generator regression: pass");
    else
      $display("cd_subq_frame_generator regression: fail");
    $finish;
  end

endmodule
